// File: sv/bvm_pkg.sv
// bvm_pkg: shared types and constants for the battery voltage monitor.
// Used by bvm_ctrl, bvm_div, bvm_datapath and battery_voltage_monitor.
`default_nettype none
package bvm_pkg;

  localparam int unsigned CAL_W   = 12;
  localparam int unsigned MV_W    = 16;
  localparam int unsigned RES_W   = 10;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned SUP_W   = 24;  // 3300 * 4095 fits in 24 bits
  localparam int unsigned MS_W    = 36;  // sense * supply
  localparam int unsigned NUM_W   = 47;  // sense * supply * (top + bottom)
  localparam int unsigned DEN_W   = 22;  // 4095 * bottom
  localparam int unsigned SUM_W   = 11;
  localparam int unsigned STEP_W  = 5;

  localparam logic [CAL_W-1:0]  CAL_MV        = 12'd3300;
  localparam logic [CNT_W-1:0]  ADC_FULL      = 12'd4095;
  localparam logic [MV_W-1:0]   LEVEL_LOW_MV  = 16'd3000;
  localparam logic [MV_W-1:0]   LEVEL_HIGH_MV = 16'd3600;
  localparam logic [MV_W-1:0]   MV_MAX        = 16'hFFFF;
  localparam logic [PCT_W-1:0]  PCT_FULL      = 7'd100;
  // floor(d / 6) == (d * 683) >> 12 for d < 600
  localparam logic [9:0]        LEVEL_RECIP   = 10'd683;
  localparam int unsigned       LEVEL_SHIFT   = 12;

  localparam logic [STEP_W-1:0] DIV1_LAST = 5'd23;
  localparam logic [STEP_W-1:0] DIV2_LAST = 5'd15;

  localparam logic [RES_W-1:0]  TOP_RESET    = 10'd120;
  localparam logic [RES_W-1:0]  BOTTOM_RESET = 10'd300;

  typedef enum logic [1:0] {
    CFG_REF_CAL    = 2'd0,
    CFG_MIN_TX     = 2'd1,
    CFG_DIV_TOP    = 2'd2,
    CFG_DIV_BOTTOM = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MV_SEL_CHECK,
    MV_SEL_CACHE,
    MV_SEL_SAT,
    MV_SEL_QUOT
  } mv_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV1,
    S_MULS,
    S_MULT,
    S_SAT,
    S_DIV2,
    S_FIN
  } state_e;

  typedef struct packed {
    logic    capture;
    logic    div1_init;
    logic    div2_init;
    logic    div_step;
    logic    mul_sense;
    logic    mul_num;
    logic    load_out;
    mv_sel_e mv_sel;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic zero_count;
    logic sat;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: sv/bvm_ctrl.sv
// bvm_ctrl: sequencer for one battery transaction.
// Depends on bvm_pkg; drives bvm_datapath through cmd_t, reads status_t.
`default_nettype none
module bvm_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  bvm_pkg::status_t   status_i,
  output bvm_pkg::cmd_t      cmd_o
);

  bvm_pkg::state_e                state_q, state_d;
  bvm_pkg::mv_sel_e               sel_q, sel_d;
  logic [bvm_pkg::STEP_W-1:0]     step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bvm_pkg::S_IDLE;
      sel_q   <= bvm_pkg::MV_SEL_CHECK;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mv_sel = sel_q;
    unique case (state_q)
      bvm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = bvm_pkg::S_PREP;
        end
      end
      bvm_pkg::S_PREP: begin
        step_d = '0;
        if (status_i.mode) begin
          sel_d   = bvm_pkg::MV_SEL_CHECK;
          state_d = bvm_pkg::S_FIN;
        end else if (status_i.zero_count) begin
          sel_d   = bvm_pkg::MV_SEL_CACHE;
          state_d = bvm_pkg::S_FIN;
        end else begin
          sel_d   = bvm_pkg::MV_SEL_QUOT;
          cmd_o.div1_init = 1'b1;
          state_d = bvm_pkg::S_DIV1;
        end
      end
      bvm_pkg::S_DIV1: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == bvm_pkg::DIV1_LAST) begin
          state_d = bvm_pkg::S_MULS;
        end
      end
      bvm_pkg::S_MULS: begin
        cmd_o.mul_sense = 1'b1;
        state_d = bvm_pkg::S_MULT;
      end
      bvm_pkg::S_MULT: begin
        cmd_o.mul_num = 1'b1;
        state_d = bvm_pkg::S_SAT;
      end
      bvm_pkg::S_SAT: begin
        step_d = '0;
        if (status_i.sat) begin
          sel_d   = bvm_pkg::MV_SEL_SAT;
          state_d = bvm_pkg::S_FIN;
        end else begin
          cmd_o.div2_init = 1'b1;
          state_d = bvm_pkg::S_DIV2;
        end
      end
      bvm_pkg::S_DIV2: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == bvm_pkg::DIV2_LAST) begin
          state_d = bvm_pkg::S_FIN;
        end
      end
      bvm_pkg::S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = bvm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bvm_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/bvm_div.sv
// bvm_div: shared restoring divider, one quotient bit per step.
// Depends on bvm_pkg; quotient bits shift into the low end of dvd_o.
`default_nettype none
module bvm_div (
  input  wire                              clk_i,
  input  wire                              init_i,
  input  wire                              step_i,
  input  wire  [bvm_pkg::DEN_W-1:0]        init_rem_i,
  input  wire  [bvm_pkg::NUM_W-1:0]        init_dvd_i,
  input  wire  [bvm_pkg::DEN_W-1:0]        divisor_i,
  output logic [bvm_pkg::NUM_W-1:0]        dvd_o
);

  logic [bvm_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [bvm_pkg::NUM_W-1:0] dvd_q, dvd_d;
  logic [bvm_pkg::DEN_W-1:0] div_q, div_d;
  logic [bvm_pkg::DEN_W:0]   trial;
  logic [bvm_pkg::DEN_W:0]   diff;
  logic                      ge;

  assign trial = {rem_q, dvd_q[bvm_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    div_d = div_q;
    if (init_i) begin
      rem_d = init_rem_i;
      dvd_d = init_dvd_i;
      div_d = divisor_i;
    end else if (step_i) begin
      rem_d = ge ? diff[bvm_pkg::DEN_W-1:0] : trial[bvm_pkg::DEN_W-1:0];
      dvd_d = {dvd_q[bvm_pkg::NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign dvd_o = dvd_q;

endmodule
`default_nettype wire

// File: sv/bvm_datapath.sv
// bvm_datapath: config registers, operand capture, multipliers, divider,
// stored reading and output register. Depends on bvm_pkg and bvm_div.
`default_nettype none
module bvm_datapath (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [1:0]                     cfg_idx_i,
  input  wire  [bvm_pkg::MV_W-1:0]       cfg_wdata_i,
  input  wire                            mode_i,
  input  wire  [bvm_pkg::CNT_W-1:0]      ref_count_i,
  input  wire  [bvm_pkg::CNT_W-1:0]      sense_count_i,
  input  wire  [bvm_pkg::MV_W-1:0]       check_mv_i,
  input  bvm_pkg::cmd_t                  cmd_i,
  output bvm_pkg::status_t               status_o,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [bvm_pkg::MV_W-1:0]       battery_mv_o,
  output logic [bvm_pkg::PCT_W-1:0]      level_pct_o,
  output logic                           tx_allowed_o,
  output logic                           used_cached_o
);

  logic [bvm_pkg::CAL_W-1:0] cal_q;
  logic [bvm_pkg::MV_W-1:0]  min_tx_q;
  logic [bvm_pkg::RES_W-1:0] top_q;
  logic [bvm_pkg::RES_W-1:0] bottom_q;
  logic [bvm_pkg::MV_W-1:0]  last_good_q;
  logic                      out_valid_q;

  logic                      mode_q;
  logic [bvm_pkg::CNT_W-1:0] ref_q;
  logic [bvm_pkg::CNT_W-1:0] sense_q;
  logic [bvm_pkg::MV_W-1:0]  check_q;
  logic [bvm_pkg::MS_W-1:0]  ms_q;
  logic [bvm_pkg::NUM_W-1:0] num_q;
  logic [bvm_pkg::DEN_W-1:0] den_q;

  logic [bvm_pkg::MV_W-1:0]  mv_q;
  logic [bvm_pkg::PCT_W-1:0] pct_q;
  logic                      tx_q;
  logic                      cached_q;

  logic [bvm_pkg::SUP_W-1:0] cal_prod;
  logic [bvm_pkg::SUM_W-1:0] res_sum;
  logic [bvm_pkg::NUM_W-1:0] dvd;
  logic                      div_init;
  logic [bvm_pkg::DEN_W-1:0] init_rem;
  logic [bvm_pkg::NUM_W-1:0] init_dvd;
  logic [bvm_pkg::DEN_W-1:0] init_div;

  logic [bvm_pkg::MV_W-1:0]  mv_d;
  logic [bvm_pkg::PCT_W-1:0] pct_d;
  logic                      tx_d;
  logic                      store_good;
  logic [9:0]                lvl_off;
  logic [19:0]               lvl_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q    <= '0;
      min_tx_q <= '0;
      top_q    <= bvm_pkg::TOP_RESET;
      bottom_q <= bvm_pkg::BOTTOM_RESET;
    end else if (cfg_we_i) begin
      unique case (bvm_pkg::cfg_idx_e'(cfg_idx_i))
        bvm_pkg::CFG_REF_CAL:    cal_q    <= cfg_wdata_i[bvm_pkg::CAL_W-1:0];
        bvm_pkg::CFG_MIN_TX:     min_tx_q <= cfg_wdata_i;
        bvm_pkg::CFG_DIV_TOP:    top_q    <= cfg_wdata_i[bvm_pkg::RES_W-1:0];
        bvm_pkg::CFG_DIV_BOTTOM: bottom_q <= cfg_wdata_i[bvm_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      ref_q   <= ref_count_i;
      sense_q <= sense_count_i;
      check_q <= check_mv_i;
    end
  end

  // Supply = 3300 * cal / ref, battery = sense * supply * sum / (4095 * bottom)
  assign cal_prod = bvm_pkg::SUP_W'(cal_q) * bvm_pkg::SUP_W'(bvm_pkg::CAL_MV);
  assign res_sum  = bvm_pkg::SUM_W'(top_q) + bvm_pkg::SUM_W'(bottom_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sense) begin
      ms_q <= bvm_pkg::MS_W'(sense_q) * bvm_pkg::MS_W'(dvd[bvm_pkg::SUP_W-1:0]);
    end
    if (cmd_i.mul_num) begin
      num_q <= bvm_pkg::NUM_W'(ms_q) * bvm_pkg::NUM_W'(res_sum);
      den_q <= bvm_pkg::DEN_W'(bottom_q) * bvm_pkg::DEN_W'(bvm_pkg::ADC_FULL);
    end
  end

  assign div_init = cmd_i.div1_init | cmd_i.div2_init;

  always_comb begin
    if (cmd_i.div2_init) begin
      // num < den << 16 here, so the upper remainder fits in DEN_W bits
      init_rem = num_q[bvm_pkg::DEN_W+bvm_pkg::MV_W-1:bvm_pkg::MV_W];
      init_dvd = {num_q[bvm_pkg::MV_W-1:0], (bvm_pkg::NUM_W-bvm_pkg::MV_W)'(0)};
      init_div = den_q;
    end else begin
      init_rem = '0;
      init_dvd = {cal_prod, (bvm_pkg::NUM_W-bvm_pkg::SUP_W)'(0)};
      init_div = bvm_pkg::DEN_W'(ref_q);
    end
  end

  bvm_div u_div (
    .clk_i      (clk_i),
    .init_i     (div_init),
    .step_i     (cmd_i.div_step),
    .init_rem_i (init_rem),
    .init_dvd_i (init_dvd),
    .divisor_i  (init_div),
    .dvd_o      (dvd)
  );

  assign status_o.mode       = mode_q;
  assign status_o.zero_count = (ref_q == '0) || (sense_q == '0);
  assign status_o.sat        = num_q >= {(bvm_pkg::NUM_W-bvm_pkg::DEN_W-bvm_pkg::MV_W)'(0),
                                         den_q, bvm_pkg::MV_W'(0)};
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    store_good = 1'b0;
    unique case (cmd_i.mv_sel)
      bvm_pkg::MV_SEL_CHECK: mv_d = check_q;
      bvm_pkg::MV_SEL_CACHE: mv_d = last_good_q;
      bvm_pkg::MV_SEL_SAT: begin
        mv_d = bvm_pkg::MV_MAX;
        store_good = 1'b1;
      end
      bvm_pkg::MV_SEL_QUOT: begin
        mv_d = dvd[bvm_pkg::MV_W-1:0];
        store_good = 1'b1;
      end
      default: mv_d = check_q;
    endcase
  end

  assign lvl_off  = 10'(mv_d - bvm_pkg::LEVEL_LOW_MV);
  assign lvl_prod = 20'(lvl_off) * 20'(bvm_pkg::LEVEL_RECIP);

  always_comb begin
    if (mv_d >= bvm_pkg::LEVEL_HIGH_MV) begin
      pct_d = bvm_pkg::PCT_FULL;
    end else if (mv_d <= bvm_pkg::LEVEL_LOW_MV) begin
      pct_d = '0;
    end else begin
      pct_d = lvl_prod[bvm_pkg::LEVEL_SHIFT+bvm_pkg::PCT_W-1:bvm_pkg::LEVEL_SHIFT];
    end
  end

  assign tx_d = (min_tx_q == '0) || (mv_d == '0) || (mv_d >= min_tx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_good_q <= '0;
    end else begin
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_out && store_good) begin
        last_good_q <= mv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mv_q     <= mv_d;
      pct_q    <= pct_d;
      tx_q     <= tx_d;
      cached_q <= (cmd_i.mv_sel == bvm_pkg::MV_SEL_CACHE);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign battery_mv_o  = mv_q;
  assign level_pct_o   = pct_q;
  assign tx_allowed_o  = tx_q;
  assign used_cached_o = cached_q;

endmodule
`default_nettype wire

// File: sv/battery_voltage_monitor.sv
// battery_voltage_monitor: top level, ratiometric battery voltage monitor.
// Depends on bvm_pkg, bvm_ctrl, bvm_datapath (with bvm_div).
//
// Input channel (in_valid_i/in_ready_o): one transaction carries mode, the
// reference and divider-tap ADC counts and a millivolt value for check mode.
// Output channel (out_valid_o/out_ready_i): one transaction per input with
// battery_mv, level_pct, tx_allowed and used_cached.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i;
// write only while no transaction is in flight.
// Check mode and a zero count go straight to the output stage; otherwise the
// measure path runs the shared one-bit-per-cycle divider: 24 steps for the
// supply and 16 for the battery reading, and a saturated reading skips the
// second division. A new input can be taken in the cycle after the result
// is loaded, so the block works on one transaction at a time.
// A finished result waits in the output register; the next input is taken
// meanwhile, and the block holds its result until out_ready_i frees it.
// Reset clears the stored reading to 0 and loads the register defaults.
`default_nettype none
module battery_voltage_monitor (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [1:0]                   cfg_idx_i,
  input  wire  [bvm_pkg::MV_W-1:0]     cfg_wdata_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          mode_i,
  input  wire  [bvm_pkg::CNT_W-1:0]    ref_count_i,
  input  wire  [bvm_pkg::CNT_W-1:0]    sense_count_i,
  input  wire  [bvm_pkg::MV_W-1:0]     check_mv_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [bvm_pkg::MV_W-1:0]     battery_mv_o,
  output logic [bvm_pkg::PCT_W-1:0]    level_pct_o,
  output logic                         tx_allowed_o,
  output logic                         used_cached_o
);

  bvm_pkg::cmd_t    cmd;
  bvm_pkg::status_t status;

  bvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bvm_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .ref_count_i   (ref_count_i),
    .sense_count_i (sense_count_i),
    .check_mv_i    (check_mv_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .battery_mv_o  (battery_mv_o),
    .level_pct_o   (level_pct_o),
    .tx_allowed_o  (tx_allowed_o),
    .used_cached_o (used_cached_o)
  );

endmodule
`default_nettype wire
